### hdl/emgbp_pkg.sv
// emgbp_pkg: shared types and constants for the EMG band-pass envelope detector.
// No dependencies.
`default_nettype none
package emgbp_pkg;
  localparam int NUM_SECTIONS = 4;
  localparam int WINDOW = 128;
  localparam int WIN_AW = $clog2(WINDOW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MUL_A1, ST_MUL_A2, ST_X, ST_MUL_B0, ST_MUL_B1, ST_MUL_B2,
    ST_SEC_OUT, ST_NEXT, ST_WIN_RD, ST_WIN_UPD, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_MAC_A1, OP_MAC_A2, OP_X, OP_MAC_B, OP_SEC_OUT, OP_WIN_UPD
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sec;
    logic [1:0] btap;
    logic       win_rd;
  } cmd_t;

  function automatic logic signed [15:0] coef_a1(input logic [1:0] s);
    case (s)
      2'd0: coef_a1 = 16'sd845;
      2'd1: coef_a1 = -16'sd8838;
      2'd2: coef_a1 = 16'sd7753;
      default: coef_a1 = -16'sd16419;
    endcase
  endfunction

  function automatic logic signed [15:0] coef_a2(input logic [1:0] s);
    case (s)
      2'd0: coef_a2 = 16'sd5955;
      2'd1: coef_a2 = 16'sd6515;
      2'd2: coef_a2 = 16'sd11591;
      default: coef_a2 = 16'sd12209;
    endcase
  endfunction

  localparam logic signed [15:0] SEC0_B0 = 16'sd304;
  localparam logic signed [15:0] SEC0_B1 = 16'sd608;
endpackage
`default_nettype wire

### hdl/emgbp_datapath.sv
// emgbp_datapath: shared multiply-accumulate, biquad state, moving-sum window.
// Depends on emgbp_pkg.
`default_nettype none
module emgbp_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire emgbp_pkg::cmd_t    cmd,
  input  wire logic [9:0]         sample,
  input  wire logic [11:0]        threshold,
  output logic signed [11:0]      filtered,
  output logic [11:0]             envelope,
  output logic                    bad_posture
);
  localparam int AW = emgbp_pkg::WIN_AW;
  localparam int SW = AW + 11;

  logic signed [31:0] z [8];
  logic signed [31:0] v;
  logic signed [31:0] xr;
  logic signed [37:0] acc;
  logic signed [47:0] prod;
  logic signed [15:0] mc;
  logic signed [31:0] mv;
  logic signed [37:0] rnd;
  logic signed [31:0] z1, z2;
  logic [10:0] mem [emgbp_pkg::WINDOW];
  logic [10:0] old_mag;
  logic [AW-1:0] wpos;
  logic [SW-1:0] wsum;
  logic filled;
  logic signed [11:0] filt_c;
  logic [10:0] mag_c;
  logic [SW-1:0] sum_c;
  logic [11:0] env_c;
  logic [2:0] zi1, zi2;

  assign zi1 = {cmd.sec, 1'b0};
  assign zi2 = {cmd.sec, 1'b1};
  assign z1 = z[zi1];
  assign z2 = z[zi2];

  function automatic logic signed [31:0] sat(input logic signed [37:0] a);
    if (a > 38'sd2147483647) sat = 32'h7fffffff;
    else if (a < -38'sd2147483648) sat = 32'h80000000;
    else sat = a[31:0];
  endfunction

  always_comb begin
    mc = emgbp_pkg::coef_a1(cmd.sec);
    mv = z1;
    case (cmd.op)
      emgbp_pkg::OP_MAC_A2: begin
        mc = emgbp_pkg::coef_a2(cmd.sec);
        mv = z2;
      end
      emgbp_pkg::OP_MAC_B: begin
        case (cmd.btap)
          2'd0: begin mc = emgbp_pkg::SEC0_B0; mv = xr; end
          2'd1: begin mc = emgbp_pkg::SEC0_B1; mv = z1; end
          default: begin mc = emgbp_pkg::SEC0_B0; mv = z2; end
        endcase
      end
      default: ;
    endcase
    prod = 48'(mc) * 48'(mv);
    rnd = 38'((prod + 48'sd8192) >>> 14);
  end

  always_comb begin
    logic [31:0] m;
    logic [11:0] q;
    m = '0;
    if (!v[31]) begin
      q = (v[31:20] > 12'd2047) ? 12'd2047 : v[31:20];
      filt_c = q;
    end else begin
      m = 32'(-33'(v));
      q = (m[31:20] > 12'd2048) ? 12'd2048 : m[31:20];
      filt_c = 12'(-13'(q));
    end
    mag_c = filt_c[11] ? ((filt_c == -12'sd2048) ? 11'd2047 : 11'(-filt_c))
                       : filt_c[10:0];
    sum_c = wsum - SW'(old_mag) + SW'(mag_c);
    env_c = {sum_c[SW-1:AW], 1'b0};
  end

  // entries not yet written since reset read as zero until the position wraps
  always_ff @(posedge clk) begin
    if (cmd.win_rd) old_mag <= filled ? mem[wpos] : 11'd0;
    if (cmd.op == emgbp_pkg::OP_WIN_UPD) mem[wpos] <= mag_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) z[i] <= '0;
      wsum <= '0;
      wpos <= '0;
      filled <= 1'b0;
      bad_posture <= 1'b0;
      envelope <= '0;
      filtered <= '0;
    end else begin
      case (cmd.op)
        emgbp_pkg::OP_LOAD: v <= {2'b00, sample, 20'd0};
        emgbp_pkg::OP_MAC_A1: acc <= 38'(v) - rnd;
        emgbp_pkg::OP_MAC_A2: acc <= acc - rnd;
        emgbp_pkg::OP_X: begin
          xr <= sat(acc);
          acc <= '0;
        end
        emgbp_pkg::OP_MAC_B: acc <= acc + rnd;
        emgbp_pkg::OP_SEC_OUT: begin
          if (cmd.sec == 2'd0) v <= sat(acc);
          else if (cmd.sec == 2'd2)
            v <= sat(38'(xr) + (38'(z1) <<< 1) + 38'(z2));
          else
            v <= sat(38'(xr) - (38'(z1) <<< 1) + 38'(z2));
          z[zi2] <= z1;
          z[zi1] <= xr;
        end
        emgbp_pkg::OP_WIN_UPD: begin
          wsum <= sum_c;
          if (32'(wpos) == emgbp_pkg::WINDOW - 1) begin
            wpos <= '0;
            filled <= 1'b1;
          end else begin
            wpos <= wpos + 1'b1;
          end
          filtered <= filt_c;
          envelope <= env_c;
          bad_posture <= env_c > threshold;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/emgbp_ctrl.sv
// emgbp_ctrl: sequencer for the biquad cascade and window update.
// Depends on emgbp_pkg.
`default_nettype none
module emgbp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output emgbp_pkg::cmd_t      cmd
);
  emgbp_pkg::state_t state, state_next;
  logic [1:0] sec, sec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= emgbp_pkg::ST_IDLE;
      sec <= '0;
    end else begin
      state <= state_next;
      sec <= sec_next;
    end
  end

  always_comb begin
    state_next = state;
    sec_next = sec;
    cmd = '{op: emgbp_pkg::OP_NONE, sec: sec, btap: 2'd0, win_rd: 1'b0};
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      emgbp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = emgbp_pkg::OP_LOAD;
          sec_next = '0;
          state_next = emgbp_pkg::ST_MUL_A1;
        end
      end
      emgbp_pkg::ST_MUL_A1: begin
        cmd.op = emgbp_pkg::OP_MAC_A1; state_next = emgbp_pkg::ST_MUL_A2;
      end
      emgbp_pkg::ST_MUL_A2: begin
        cmd.op = emgbp_pkg::OP_MAC_A2; state_next = emgbp_pkg::ST_X;
      end
      emgbp_pkg::ST_X: begin
        cmd.op = emgbp_pkg::OP_X;
        state_next = (sec == 2'd0) ? emgbp_pkg::ST_MUL_B0 : emgbp_pkg::ST_SEC_OUT;
      end
      emgbp_pkg::ST_MUL_B0: begin
        cmd.op = emgbp_pkg::OP_MAC_B; cmd.btap = 2'd0; state_next = emgbp_pkg::ST_MUL_B1;
      end
      emgbp_pkg::ST_MUL_B1: begin
        cmd.op = emgbp_pkg::OP_MAC_B; cmd.btap = 2'd1; state_next = emgbp_pkg::ST_MUL_B2;
      end
      emgbp_pkg::ST_MUL_B2: begin
        cmd.op = emgbp_pkg::OP_MAC_B; cmd.btap = 2'd2; state_next = emgbp_pkg::ST_SEC_OUT;
      end
      emgbp_pkg::ST_SEC_OUT: begin
        cmd.op = emgbp_pkg::OP_SEC_OUT;
        if (sec == 2'd3) begin
          state_next = emgbp_pkg::ST_WIN_RD;
        end else begin
          sec_next = sec + 2'd1;
          state_next = emgbp_pkg::ST_MUL_A1;
        end
      end
      emgbp_pkg::ST_WIN_RD: begin
        cmd.win_rd = 1'b1; state_next = emgbp_pkg::ST_WIN_UPD;
      end
      emgbp_pkg::ST_WIN_UPD: begin
        cmd.op = emgbp_pkg::OP_WIN_UPD; state_next = emgbp_pkg::ST_OUT;
      end
      emgbp_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = emgbp_pkg::ST_IDLE;
      end
      default: state_next = emgbp_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### hdl/emg_bandpass_envelope_detector_unit.sv
// Top level: EMG band-pass envelope detector.
// One shared MAC steps through four biquad sections, then a window read and
// update, before the result is valid. A new request is accepted only after
// the previous result has been taken (out_stall low).
// Reset (rst, synchronous): clears filter state, window sum and position,
// threshold to 30. Window entries read as zero until the position first wraps.
`default_nettype none
module emg_bandpass_envelope_detector_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [9:0]        sample,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [11:0]     filtered,
  output logic [11:0]            envelope,
  output logic                   bad_posture,
  input  wire logic              cfg_we,
  input  wire logic [11:0]       cfg_data
);
  emgbp_pkg::cmd_t cmd;
  logic [11:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) threshold <= 12'd30;
    else if (cfg_we) threshold <= cfg_data;
  end

  emgbp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
  );

  emgbp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sample(sample), .threshold(threshold),
    .filtered(filtered), .envelope(envelope), .bad_posture(bad_posture)
  );
endmodule
`default_nettype wire

### hdl/emgbp_checker.sv
// emgbp_checker: port-level checks for the envelope detector top level.
// Bound to emg_bandpass_envelope_detector_unit.
`default_nettype none
module emgbp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [11:0] envelope,
  input wire logic        bad_posture
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request accepted while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(envelope))
    else $error("result dropped under stall");
  a_env_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !envelope[0]) else $error("odd envelope");
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && envelope == 12'd0) |-> !bad_posture) else $error("flag at zero");
endmodule

bind emg_bandpass_envelope_detector_unit emgbp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .envelope(envelope),
  .bad_posture(bad_posture)
);
`default_nettype wire
